// ----- rtl/core/afu_pkg.sv -----
// Package for the activation function unit: kind codes, widths and exponential tables.
`default_nettype none

package afu_pkg;

  // Activation kind codes held in the configuration register
  typedef enum logic [1:0] {
    KIND_TANH    = 2'd0,
    KIND_RELU    = 2'd1,
    KIND_SIGMOID = 2'd2,
    KIND_FAST    = 2'd3
  } act_kind_t;

  localparam int X_W        = 12;  // pre-activation, signed Q3.8
  localparam int ACT_W      = 18;  // activated, signed Q3.14
  localparam int DER_W      = 16;  // derivative, signed Q1.14
  localparam int Q14_ONE    = 16384;

  localparam int EXP_FRAC   = 46;             // fraction bits of e^-t
  localparam int EXP_W      = EXP_FRAC + 1;   // holds 1.0 as well
  localparam int DIV_W      = EXP_W + 1;      // 1 + e^-t
  localparam int DIV_STEPS  = 16;             // quotient bits of 1/(1 + e^-t)

  localparam int EXP_HI_N   = 32;
  localparam int EXP_LO_N   = 256;

  typedef logic [EXP_W-1:0] exp_hi_tab_t [EXP_HI_N];
  typedef logic [EXP_W-1:0] exp_lo_tab_t [EXP_LO_N];

  // e^-j for whole steps j
  function automatic exp_hi_tab_t build_exp_hi();
    exp_hi_tab_t tab;
    real         v;
    for (int i = 0; i < EXP_HI_N; i++) begin
      v      = $exp(-real'(i)) * (2.0 ** EXP_FRAC);
      tab[i] = EXP_W'(longint'(v));
    end
    return tab;
  endfunction

  // e^-(j/256) for the fractional step j
  function automatic exp_lo_tab_t build_exp_lo();
    exp_lo_tab_t tab;
    real         v;
    for (int i = 0; i < EXP_LO_N; i++) begin
      v      = $exp(-real'(i) / 256.0) * (2.0 ** EXP_FRAC);
      tab[i] = EXP_W'(longint'(v));
    end
    return tab;
  endfunction

  localparam exp_hi_tab_t EXP_HI = build_exp_hi();
  localparam exp_lo_tab_t EXP_LO = build_exp_lo();

endpackage

`default_nettype wire

// ----- rtl/core/activation_function_unit.sv -----
// Activation function unit: tanh, relu, sigmoid and fast sigmoid with derivative.
`default_nettype none

// Takes one signed Q3.8 pre-activation value per beat and returns the activated
// value (signed Q3.14) and its derivative (signed Q1.14). The kind is picked by
// cfg_wr_data on a cfg_wr_en pulse (0 tanh, 1 relu, 2 sigmoid, 3 fast sigmoid;
// fast sigmoid after reset); write it only while no beat is in flight.
// A new beat can enter on every clock while in_ready is high. The input register
// and two more stages build e^-t from two tables and a split multiply, 17 stages
// carry the restoring divider (one quotient bit per stage for 1/(1+e^-t) or
// |x|/(1+|x|)), and 3 stages form the activated value, the product for the
// derivative and the rounding, then the output register.
// A two-entry output buffer lets one more beat move through while a result
// waits; in_ready drops only while both entries are full.
module activation_function_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_wr_en,
  input  wire [1:0]                      cfg_wr_data,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire signed [afu_pkg::X_W-1:0]  in_pre_activation,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic signed [afu_pkg::ACT_W-1:0] out_activated,
  output logic signed [afu_pkg::DER_W-1:0] out_derivative
);
  import afu_pkg::*;

  localparam int NST   = DIV_STEPS + 7;  // s0, s1, s2, divider, a, product, final
  localparam int DIV_N = DIV_STEPS + 1;

  act_kind_t cfg_kind_r;
  logic      en;
  logic [NST-1:0] vld_r;

  // stage 0
  logic signed [X_W-1:0] s0_x_r;
  act_kind_t             s0_kind_r;
  logic [X_W-1:0]        s0_mag;
  logic [X_W:0]          s0_k;

  // stage 1
  logic signed [X_W-1:0] s1_x_r;
  act_kind_t             s1_kind_r;
  logic [X_W-1:0]        s1_mag_r;
  logic [EXP_W-1:0]      s1_ehi_r;
  logic [EXP_W-1:0]      s1_elo_r;

  // stage 2
  logic signed [X_W-1:0] s2_x_r;
  act_kind_t             s2_kind_r;
  logic [X_W-1:0]        s2_mag_r;
  logic [45:0]           s2_hh_r;
  logic [46:0]           s2_hl_r;
  logic [46:0]           s2_lh_r;
  logic [47:0]           s2_ll_r;
  logic [93:0]           s2_prod;
  logic [EXP_W-1:0]      s2_exp;
  logic [DIV_W-1:0]      s2_num_nxt;
  logic [DIV_W-1:0]      s2_den_nxt;

  // divider stages
  logic [DIV_W-1:0]      div_rem_r  [DIV_N];
  logic [DIV_W-1:0]      div_den_r  [DIV_N];
  logic [DIV_STEPS-1:0]  div_quo_r  [DIV_N];
  logic signed [X_W-1:0] div_x_r    [DIV_N];
  act_kind_t             div_kind_r [DIV_N];
  logic [DIV_W:0]        div_trial  [DIV_STEPS];
  logic [DIV_W-1:0]      div_rem_nxt[DIV_STEPS];
  logic [DIV_STEPS-1:0]  div_quo_nxt[DIV_STEPS];

  // activated value stage
  logic [DIV_STEPS-1:0]    dq;
  logic signed [X_W-1:0]   dx;
  act_kind_t               dkind;
  logic [DIV_STEPS-1:0]    tanh_mag;
  logic [14:0]             sig_pos;
  logic signed [ACT_W-1:0] a_nxt;
  logic signed [ACT_W-1:0] sa_act_r;
  act_kind_t               sa_kind_r;
  logic                    sa_pos_r;

  // product stage
  logic signed [16:0]      m_lhs;
  logic signed [16:0]      m_rhs;
  logic signed [33:0]      m_full;
  logic signed [31:0]      sm_prod_r;
  logic signed [ACT_W-1:0] sm_act_r;
  act_kind_t               sm_kind_r;
  logic                    sm_pos_r;

  // final stage
  logic [31:0]             r_mag;
  logic [31:0]             r_sum;
  logic [31:0]             r_q;
  logic signed [DER_W-1:0] der_nxt;
  logic signed [ACT_W-1:0] sf_act_r;
  logic signed [DER_W-1:0] sf_der_r;

  // output buffer
  logic                    out_vld_r;
  logic signed [ACT_W-1:0] out_act_r;
  logic signed [DER_W-1:0] out_der_r;
  logic                    skid_vld_r;
  logic signed [ACT_W-1:0] skid_act_r;
  logic signed [DER_W-1:0] skid_der_r;
  logic                    ex_vld;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_kind_r <= KIND_FAST;
    end else if (cfg_wr_en) begin
      cfg_kind_r <= act_kind_t'(cfg_wr_data);
    end
  end

  // Advance the whole pipe while the skid entry is free
  assign en       = !skid_vld_r;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- stage 0
  always_ff @(posedge clk) begin
    if (en) begin
      s0_x_r    <= in_pre_activation;
      s0_kind_r <= cfg_kind_r;
    end
  end

  // tanh needs e^-2|x|, sigmoid e^-|x|
  always_comb begin
    s0_mag = s0_x_r[X_W-1] ? X_W'(-s0_x_r) : X_W'(s0_x_r);
    s0_k   = (s0_kind_r == KIND_TANH) ? {s0_mag, 1'b0} : {1'b0, s0_mag};
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r    <= s0_x_r;
      s1_kind_r <= s0_kind_r;
      s1_mag_r  <= s0_mag;
      s1_ehi_r  <= EXP_HI[s0_k[X_W:8]];
      s1_elo_r  <= EXP_LO[s0_k[7:0]];
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Split the table product into four partial products
  always_ff @(posedge clk) begin
    if (en) begin
      s2_x_r    <= s1_x_r;
      s2_kind_r <= s1_kind_r;
      s2_mag_r  <= s1_mag_r;
      s2_hh_r   <= s1_ehi_r[46:24] * s1_elo_r[46:24];
      s2_hl_r   <= s1_ehi_r[46:24] * s1_elo_r[23:0];
      s2_lh_r   <= s1_ehi_r[23:0]  * s1_elo_r[46:24];
      s2_ll_r   <= s1_ehi_r[23:0]  * s1_elo_r[23:0];
    end
  end

  always_comb begin
    s2_prod = (94'(s2_hh_r) << 48) + (94'(s2_hl_r) << 24) + (94'(s2_lh_r) << 24)
            + 94'(s2_ll_r);
    s2_exp  = s2_prod[92:46];
    if (s2_kind_r == KIND_TANH || s2_kind_r == KIND_SIGMOID) begin
      s2_num_nxt = DIV_W'(1) << EXP_FRAC;
      s2_den_nxt = (DIV_W'(1) << EXP_FRAC) + DIV_W'(s2_exp);
    end else begin
      s2_num_nxt = DIV_W'(s2_mag_r);
      s2_den_nxt = DIV_W'(s2_mag_r) + DIV_W'(256);
    end
  end

  // ---------------------------------------------------------------- divider
  always_ff @(posedge clk) begin
    if (en) begin
      div_rem_r[0]  <= s2_num_nxt;
      div_den_r[0]  <= s2_den_nxt;
      div_quo_r[0]  <= '0;
      div_x_r[0]    <= s2_x_r;
      div_kind_r[0] <= s2_kind_r;
      for (int j = 0; j < DIV_STEPS; j++) begin
        div_rem_r[j+1]  <= div_rem_nxt[j];
        div_den_r[j+1]  <= div_den_r[j];
        div_quo_r[j+1]  <= div_quo_nxt[j];
        div_x_r[j+1]    <= div_x_r[j];
        div_kind_r[j+1] <= div_kind_r[j];
      end
    end
  end

  // One restoring step per stage: shift, trial subtract, keep or drop
  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      div_trial[j] = {div_rem_r[j], 1'b0};
      if (div_trial[j] >= {1'b0, div_den_r[j]}) begin
        div_rem_nxt[j] = DIV_W'(div_trial[j] - {1'b0, div_den_r[j]});
        div_quo_nxt[j] = {div_quo_r[j][DIV_STEPS-2:0], 1'b1};
      end else begin
        div_rem_nxt[j] = div_trial[j][DIV_W-1:0];
        div_quo_nxt[j] = {div_quo_r[j][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------- activated value
  always_comb begin
    dq       = div_quo_r[DIV_STEPS];
    dx       = div_x_r[DIV_STEPS];
    dkind    = div_kind_r[DIV_STEPS];
    // quotient holds floor(2^16 * ratio); round half up at 2^15 or 2^14
    tanh_mag = DIV_STEPS'((17'(dq) + 17'd1) >> 1) - DIV_STEPS'(Q14_ONE);
    sig_pos  = 15'((16'(dq[DIV_STEPS-1:1]) + 16'd1) >> 1);
    case (dkind)
      KIND_TANH: begin
        a_nxt = dx[X_W-1] ? ACT_W'(0) - ACT_W'(tanh_mag) : ACT_W'(tanh_mag);
      end
      KIND_RELU: begin
        a_nxt = (!dx[X_W-1] && dx != '0) ? {dx, 6'b0} : '0;
      end
      KIND_SIGMOID: begin
        a_nxt = dx[X_W-1] ? ACT_W'(Q14_ONE) - ACT_W'(sig_pos) : ACT_W'(sig_pos);
      end
      default: begin
        // fast sigmoid
        a_nxt = dx[X_W-1] ? ACT_W'(0) - ACT_W'(sig_pos) : ACT_W'(sig_pos);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_act_r  <= a_nxt;
      sa_kind_r <= dkind;
      sa_pos_r  <= !dx[X_W-1] && dx != '0;
    end
  end

  // ---------------------------------------------------------------- product
  always_comb begin
    m_lhs  = {sa_act_r[15], sa_act_r[15:0]};
    m_rhs  = (sa_kind_r == KIND_TANH) ? m_lhs : 17'(Q14_ONE) - m_lhs;
    m_full = m_lhs * m_rhs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_prod_r <= m_full[31:0];
      sm_act_r  <= sa_act_r;
      sm_kind_r <= sa_kind_r;
      sm_pos_r  <= sa_pos_r;
    end
  end

  // ---------------------------------------------------------------- derivative
  // Round the product to Q14, ties away from zero
  always_comb begin
    r_mag = sm_prod_r[31] ? 32'(-sm_prod_r) : 32'(sm_prod_r);
    r_sum = (r_mag + 32'd8192) >> 14;
    r_q   = sm_prod_r[31] ? 32'd0 - r_sum : r_sum;
    case (sm_kind_r)
      KIND_TANH:  der_nxt = DER_W'(Q14_ONE) - r_q[DER_W-1:0];
      KIND_RELU:  der_nxt = sm_pos_r ? DER_W'(Q14_ONE) : '0;
      default:    der_nxt = r_q[DER_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf_act_r <= sm_act_r;
      sf_der_r <= der_nxt;
    end
  end

  // ---------------------------------------------------------------- output buffer
  assign ex_vld = vld_r[NST-1] && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // drain the skid entry once the held beat leaves
      if (out_ready) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= ex_vld;
    end else begin
      skid_vld_r <= ex_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_ready) begin
        out_act_r <= skid_act_r;
        out_der_r <= skid_der_r;
      end
    end else if (!out_vld_r || out_ready) begin
      out_act_r <= sf_act_r;
      out_der_r <= sf_der_r;
    end else begin
      skid_act_r <= sf_act_r;
      skid_der_r <= sf_der_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_activated  = out_act_r;
  assign out_derivative = out_der_r;

endmodule

`default_nettype wire
